// ===== rtl/lipo_voltage_to_percent_top_defines.svh =====
// Assertion macros used by the LiPo charge estimator top level.
`ifndef LIPO_VOLTAGE_TO_PERCENT_TOP_DEFINES_SVH
`define LIPO_VOLTAGE_TO_PERCENT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lvp_pkg.sv =====
// Package: curve tables, widths and stage types for the LiPo charge estimator.
package lvp_pkg;

  localparam int NUM_KNEES = 21;
  localparam int SEG_W     = 5;
  localparam int MV_W      = 14;
  localparam int PCT_W     = 7;
  localparam int OFS_W     = 9;
  localparam int Q_W       = 3;

  // Resting-voltage curve, falling strictly.
  localparam logic [MV_W-1:0] KNEE_MV [NUM_KNEES] = '{
    14'd4200, 14'd4150, 14'd4110, 14'd4080, 14'd4020, 14'd3980, 14'd3950,
    14'd3910, 14'd3870, 14'd3850, 14'd3840, 14'd3820, 14'd3800, 14'd3790,
    14'd3770, 14'd3750, 14'd3730, 14'd3710, 14'd3690, 14'd3610, 14'd3270
  };

  localparam logic [PCT_W-1:0] KNEE_PCT [NUM_KNEES] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  // Millivolts per percent step for the segment ending at knee k
  // (span / 5; every span is a multiple of 5). Entry 0 has no segment.
  localparam logic [OFS_W-1:0] SEG_UNIT [NUM_KNEES] = '{
    9'd0,  9'd10, 9'd8, 9'd6, 9'd12, 9'd8, 9'd6,
    9'd8,  9'd8,  9'd4, 9'd2, 9'd4,  9'd4, 9'd2,
    9'd4,  9'd4,  9'd4, 9'd4, 9'd4,  9'd16, 9'd68
  };

  // Stage 2 contents: segment and offset into it.
  typedef struct packed {
    logic             sat_hi;
    logic             sat_lo;
    logic [SEG_W-1:0] seg;
    logic [OFS_W-1:0] offset;
  } lvp_seg_t;

endpackage

// ===== rtl/lvp_search.sv =====
// Segment search: picks the bracketing knee pair and the offset into it.
module lvp_search import lvp_pkg::*; (
  input  logic [MV_W-1:0]      mv,
  input  logic [NUM_KNEES-1:0] ge,
  output lvp_seg_t             seg_info
);

  logic [SEG_W-1:0] idx;
  logic [MV_W-1:0]  diff;

  // Smallest k >= 1 whose knee is at or below the reading.
  always_comb begin
    idx = SEG_W'(NUM_KNEES - 1);
    for (int k = NUM_KNEES - 1; k >= 1; k--) begin
      if (ge[k]) begin
        idx = SEG_W'(k);
      end
    end
  end

  assign diff = mv - KNEE_MV[idx];

  assign seg_info.sat_hi = ge[0];
  assign seg_info.sat_lo = (mv <= KNEE_MV[NUM_KNEES-1]);
  assign seg_info.seg    = idx;
  assign seg_info.offset = diff[OFS_W-1:0];

endmodule

// ===== rtl/lvp_interp.sv =====
// Interpolation: percent step count within a segment, plus saturation.
module lvp_interp import lvp_pkg::*; (
  input  lvp_seg_t         seg_info,
  output logic [PCT_W-1:0] pct
);

  logic [OFS_W-1:0] unit1;
  logic [OFS_W-1:0] unit2;
  logic [OFS_W-1:0] unit3;
  logic [OFS_W-1:0] unit4;
  logic [Q_W-1:0]   q;

  // offset < 5*unit, so the quotient offset/unit is 0..4.
  assign unit1 = SEG_UNIT[seg_info.seg];
  assign unit2 = unit1 << 1;
  assign unit3 = unit1 + unit2;
  assign unit4 = unit1 << 2;

  assign q = Q_W'(seg_info.offset >= unit1) + Q_W'(seg_info.offset >= unit2)
           + Q_W'(seg_info.offset >= unit3) + Q_W'(seg_info.offset >= unit4);

  always_comb begin
    if (seg_info.sat_hi) begin
      pct = KNEE_PCT[0];
    end else if (seg_info.sat_lo) begin
      pct = KNEE_PCT[NUM_KNEES-1];
    end else begin
      pct = KNEE_PCT[seg_info.seg] + PCT_W'(q);
    end
  end

endmodule

// ===== rtl/lipo_voltage_to_percent_top.sv =====
// Top level: three-stage pipelined LiPo voltage to state-of-charge converter.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | in_valid / in_ready  | millivolts     [13:0] unsigned
//  output   | out_valid / out_ready| charge_percent [6:0]  unsigned
//
// One transaction per cycle sustained while out_ready stays high; three
// register stages (compare, segment search, interpolation) lie in turn
// between an accepted reading and out_valid, which is driven by the last.
// Each stage holds while the stage after it is full and stalled, so a
// bubble is filled even when the output is blocked; nothing is lost or
// repeated. rst (synchronous) clears only the stage valid bits.
`include "lipo_voltage_to_percent_top_defines.svh"

module lipo_voltage_to_percent_top import lvp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MV_W-1:0]  millivolts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PCT_W-1:0] charge_percent
);

  // Stage 1: reading and its compare against every knee.
  logic                 v1;
  logic [MV_W-1:0]      mv1;
  logic [NUM_KNEES-1:0] ge1;
  logic [NUM_KNEES-1:0] ge_next;

  // Stage 2: segment index and offset.
  logic                 v2;
  lvp_seg_t             s2;
  lvp_seg_t             s2_next;

  // Stage 3: output register.
  logic                 v3;
  logic [PCT_W-1:0]     pct3;
  logic [PCT_W-1:0]     pct_next;

  logic adv1;
  logic adv2;
  logic adv3;

  // A stage loads when it is empty or its content moves on.
  assign adv3 = !v3 || out_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign in_ready = adv1;

  // Knee compares, all in parallel.
  always_comb begin
    for (int k = 0; k < NUM_KNEES; k++) begin
      ge_next[k] = (millivolts >= KNEE_MV[k]);
    end
  end

  lvp_search u_search (
    .mv       (mv1),
    .ge       (ge1),
    .seg_info (s2_next)
  );

  lvp_interp u_interp (
    .seg_info (s2),
    .pct      (pct_next)
  );

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk) begin
    if (adv1) begin
      mv1 <= millivolts;
      ge1 <= ge_next;
    end
    if (adv2) begin
      s2 <= s2_next;
    end
    if (adv3) begin
      pct3 <= pct_next;
    end
  end

  assign out_valid      = v3;
  assign charge_percent = pct3;

  // Input only blocks when every stage is full and the output is stalled.
  `LVP_ASSERT_NOW(a_full_when_blocked, clk, rst, !in_ready,
    v1 && v2 && v3 && !out_ready, "input blocked with a bubble in the pipeline")

  // An in-range reading lands on a real segment.
  `LVP_ASSERT_NOW(a_seg_range, clk, rst, v2 && !s2.sat_hi && !s2.sat_lo,
    s2.seg >= SEG_W'(1) && s2.seg <= SEG_W'(NUM_KNEES - 1), "segment index out of range")

  // An item in stage 2 that cannot move stays there.
  `LVP_ASSERT_NEXT(a_stage2_hold, clk, rst, v2 && !adv2,
    v2 && $stable(s2), "stage 2 changed while stalled")

  // Result never exceeds full charge.
  `LVP_ASSERT_NOW(a_pct_max, clk, rst, out_valid,
    charge_percent <= KNEE_PCT[0], "charge above 100 percent")

endmodule

// ===== tb/charge_percent_checker.sv =====
// Checker for the LiPo charge estimator: predicts each charge reading and compares results.
`timescale 1ns / 1ps

module charge_percent_checker import lvp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [MV_W-1:0]  millivolts,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [PCT_W-1:0] charge_percent,
  output int               mismatches,
  output int               outstanding
);

  localparam int CURVE_LEN = 21;
  localparam int MAX_REPORTS = 10;

  // Resting-voltage curve, highest point first.
  localparam int CURVE_MV [CURVE_LEN] = '{
    4200, 4150, 4110, 4080, 4020, 3980, 3950,
    3910, 3870, 3850, 3840, 3820, 3800, 3790,
    3770, 3750, 3730, 3710, 3690, 3610, 3270
  };
  localparam int CURVE_PCT [CURVE_LEN] = '{
    100, 95, 90, 85, 80, 75, 70,
    65,  60, 55, 50, 45, 40, 35,
    30,  25, 20, 15, 10, 5,  0
  };

  logic [PCT_W-1:0] pending_percent [$];

  // Linear interpolation between bracketing curve points, truncating.
  function automatic logic [PCT_W-1:0] percent_of_reading(logic [MV_W-1:0] reading);
    int mv;
    int pct;
    mv = int'(reading);
    pct = 0;
    if (mv >= CURVE_MV[0]) begin
      pct = 100;
    end else if (mv > CURVE_MV[CURVE_LEN-1]) begin
      for (int k = CURVE_LEN - 1; k >= 1; k--) begin
        if (mv >= CURVE_MV[k] && mv < CURVE_MV[k-1]) begin
          pct = CURVE_PCT[k] + ((mv - CURVE_MV[k]) * (CURVE_PCT[k-1] - CURVE_PCT[k]))
                / (CURVE_MV[k-1] - CURVE_MV[k]);
        end
      end
    end
    return PCT_W'(pct);
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    logic [PCT_W-1:0] want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_percent.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("checker: unexpected result charge_percent=%0d at %0t",
                     charge_percent, $realtime);
        end else begin
          want = pending_percent.pop_front();
          if (charge_percent !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORTS)
              $display("checker: charge_percent expected %0d got %0d at %0t",
                       want, charge_percent, $realtime);
          end
        end
      end
      if (in_valid && in_ready)
        pending_percent.push_back(percent_of_reading(millivolts));
      outstanding <= pending_percent.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives readings into the LiPo charge estimator and gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import lvp_pkg::*;

  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 215;
  localparam int LONG_HOLD    = 120;   // receiver hold-off in cycles
  localparam int TAIL_CYCLES  = 8;     // settle time after the last result
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [MV_W-1:0]  millivolts = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PCT_W-1:0] charge_percent;

  int mismatches;
  int outstanding;

  // Idle profile for the sender and receiver processes, set by the stimulus.
  int tx_gap_max  = 0;
  int rx_stall_max = 0;
  bit rx_long_hold = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  lipo_voltage_to_percent_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .millivolts     (millivolts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .charge_percent (charge_percent)
  );

  charge_percent_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .millivolts     (millivolts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .charge_percent (charge_percent),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Offer one reading after a random gap and hold it until the transaction.
  // With a zero gap valid stays high straight into the next reading.
  task automatic offer_reading(input logic [MV_W-1:0] mv);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    millivolts <= mv;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly the interesting band around the curve, some below it, the rest anywhere in the field.
  function automatic logic [MV_W-1:0] draw_reading();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 70)
      return MV_W'($urandom_range(4215, 3255));
    else if (pick < 80)
      return MV_W'($urandom_range(3300, 0));
    else
      return MV_W'($urandom_range(16383, 0));
  endfunction

  // Sender holds still until every prediction has been matched by a result.
  // It first lets the checker record the transaction just taken, so the count includes it.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: draws a stall per result, and honors a one-off long hold-off.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = $urandom_range(rx_stall_max, 0);
      if (rx_long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_long_hold = 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: a stuck handshake ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (!rst);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [MV_W-1:0] directed [$];
    int tx_profile [NUM_PHASES];
    int rx_profile [NUM_PHASES];

    // Field extremes, both saturation edges, inner curve points and their
    // neighbors, and high bits set far above the top of the curve.
    directed = '{14'd0, 14'd1, 14'd3269, 14'd3270, 14'd3271, 14'd3609, 14'd3610,
                 14'd3611, 14'd3689, 14'd3690, 14'd3691, 14'd3700, 14'd3795,
                 14'd3845, 14'd3840, 14'd4150, 14'd4199, 14'd4200, 14'd4201,
                 14'd8192, 14'd16383, 14'd12287, 14'd2730};

    // Idle profiles per phase: none, heavy, one-sided, light.
    tx_profile = '{0, 18, 0, 18, 6, 18};
    rx_profile = '{0, 18, 18, 0, 6, 18};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tx_gap_max   = 18;
    rx_stall_max = 18;
    foreach (directed[i]) offer_reading(directed[i]);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_gap_max   = tx_profile[p];
      rx_stall_max = rx_profile[p];
      // Long hold-off while the sender streams back to back: the pipe fills
      // and in_ready must drop.
      if (p == 0) rx_long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) offer_reading(draw_reading());
      // Pause the sender until every expected result has come back.
      drain_results();
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lvp_pkg.sv
rtl/lvp_search.sv
rtl/lvp_interp.sv
rtl/lipo_voltage_to_percent_top.sv
tb/charge_percent_checker.sv
tb/testbench.sv
